FILE: rtl/core/crs_pkg.sv
package crs_pkg;

   localparam int RESERVOIR_W = 14;
   localparam int HELD_W      = 4;
   localparam int COUNT_W     = 8;
   localparam int CODE_W      = 7;
   localparam int SAMPLE_W    = 7;
   localparam int WIDTH_W     = 3;
   localparam int MIN_PASSWORD = 16;

   typedef enum logic [1:0] {
      MODE_DIGITS   = 2'd0,
      MODE_LOWER    = 2'd1,
      MODE_ALNUM    = 2'd2,
      MODE_SPECIALS = 2'd3
   } crs_mode_type;

   localparam logic CSR_MODE   = 1'b0;
   localparam logic CSR_LENGTH = 1'b1;

   // Specials in alphabet order; the last two slots are never selected.
   localparam logic [CODE_W-1:0] SPECIAL_CHARS [16] = '{
      7'd33, 7'd64, 7'd35, 7'd36, 7'd37, 7'd94, 7'd38, 7'd42,
      7'd40, 7'd41, 7'd45, 7'd95, 7'd61, 7'd43, 7'd0,  7'd0
   };

   typedef struct packed {
      logic [CODE_W-1:0] char_code;
      logic              password_last;
      logic              run_last;
   } crs_result_type;

   typedef struct packed {
      crs_result_type             res0;
      crs_result_type             res1;
      logic [1:0]                 num;
      logic [RESERVOIR_W-1:0]     reservoir;
      logic [HELD_W-1:0]          held;
      logic [COUNT_W-1:0]         chars;
      logic                       ended;
   } crs_draw_type;

   function automatic logic [WIDTH_W-1:0] mode_width(input crs_mode_type mode);
      logic [WIDTH_W-1:0] w;
      case (mode)
         MODE_DIGITS: w = 3'd4;
         MODE_LOWER:  w = 3'd5;
         MODE_ALNUM:  w = 3'd6;
         default:     w = 3'd7;
      endcase
      return w;
   endfunction

   function automatic logic [SAMPLE_W-1:0] mode_universe(input crs_mode_type mode);
      logic [SAMPLE_W-1:0] u;
      case (mode)
         MODE_DIGITS: u = 7'd10;
         MODE_LOWER:  u = 7'd26;
         MODE_ALNUM:  u = 7'd62;
         default:     u = 7'd76;
      endcase
      return u;
   endfunction

   // Sets are laid out digits, lowercase, uppercase, specials.
   function automatic logic [CODE_W-1:0] map_symbol(input crs_mode_type mode,
                                                    input logic [SAMPLE_W-1:0] s);
      logic [CODE_W-1:0] c;
      logic [SAMPLE_W-1:0] t;
      t = s - 7'd62;
      case (mode)
         MODE_DIGITS: c = 7'd48 + s;
         MODE_LOWER:  c = 7'd97 + s;
         default: begin
            if (s < 7'd10)      c = 7'd48 + s;
            else if (s < 7'd36) c = 7'd87 + s;
            else if (s < 7'd62) c = 7'd29 + s;
            else                c = SPECIAL_CHARS[t[3:0]];
         end
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/core/charset_rejection_sampler_unit.sv
// Password character generator by rejection sampling. Each random byte taken on
// the req channel is appended, least significant bit first, to a small bit
// reservoir; samples of the width the selected alphabet needs (4, 5, 6 or 7
// bits for digits, lowercase, alphanumeric, alphanumeric plus 14 specials) are
// drawn from it, out-of-range samples are dropped, and accepted samples come
// out on the rsp channel as ASCII codes, zero, one or two per byte. tlast marks
// the character that completes a password of csr length (clamped to 16 and
// MAX_PASSWORD); the reservoir is emptied at that point. tuser marks the last
// character produced from a byte. A byte is held in an input register and
// processed by combinational logic into a two-entry result buffer; the rsp
// side drains one transaction per cycle while rsp_tready is high. A held byte
// is processed once the buffer is empty or its last entry leaves, so bytes
// giving at most one character pass one per cycle while rsp_tready is high.
// Configuration may be written only while no byte is in flight and all results have been taken.
module charset_rejection_sampler_unit #(
   parameter int MAX_PASSWORD = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rand_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] char_code, [7] zero
   output logic       rsp_tlast,   // password_last
   output logic       rsp_tuser,   // [0] run_last
   input  logic       csr_we,
   input  logic       csr_addr,
   input  logic [7:0] csr_wdata
);
   import crs_pkg::*;

   // Configuration registers.
   crs_mode_type mode_ff;
   logic [7:0]   length_ff;

   // Input holding register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // Sampler state carried from byte to byte.
   logic [RESERVOIR_W-1:0] reservoir_ff, reservoir_in;
   logic [HELD_W-1:0]      held_ff, held_in;
   logic [COUNT_W-1:0]     chars_ff, chars_in;

   // Two-entry result buffer; q0 is the head.
   crs_result_type q0_ff, q0_in;
   crs_result_type q1_ff, q1_in;
   logic [1:0]     q_count_ff, q_count_in;

   crs_draw_type draw;
   logic         req_fire;
   logic         rsp_fire;
   logic         process;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // The held byte is processed when its results can all be loaded into the
   // buffer: the buffer is empty, or its last entry leaves in this cycle.
   assign process    = in_valid_ff &&
                       (q_count_ff == 2'd0 || (q_count_ff == 2'd1 && rsp_fire));
   assign req_tready = !in_valid_ff || process;

   crs_draw #(
      .MAX_PASSWORD(MAX_PASSWORD)
   ) u_draw (
      .rand_byte       (in_byte_ff),
      .mode            (mode_ff),
      .password_length (length_ff),
      .reservoir       (reservoir_ff),
      .held            (held_ff),
      .chars           (chars_ff),
      .draw            (draw)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      reservoir_in = reservoir_ff;
      held_in      = held_ff;
      chars_in     = chars_ff;
      q0_in        = q0_ff;
      q1_in        = q1_ff;
      q_count_in   = q_count_ff;

      if (req_fire) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (process) begin
         in_valid_in = 1'b0;
      end

      if (process) begin
         reservoir_in = draw.reservoir;
         held_in      = draw.held;
         chars_in     = draw.chars;
         q0_in        = draw.res0;
         q1_in        = draw.res1;
         q_count_in   = draw.num;
      end else if (rsp_fire) begin
         q0_in      = q1_ff;
         q_count_in = q_count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_SPECIALS;
         length_ff    <= 8'(MIN_PASSWORD);
         in_valid_ff  <= 1'b0;
         reservoir_ff <= '0;
         held_ff      <= '0;
         chars_ff     <= '0;
         q_count_ff   <= '0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_MODE:   mode_ff   <= crs_mode_type'(csr_wdata[1:0]);
               CSR_LENGTH: length_ff <= csr_wdata;
               default: ;
            endcase
         end
         in_valid_ff  <= in_valid_in;
         reservoir_ff <= reservoir_in;
         held_ff      <= held_in;
         chars_ff     <= chars_in;
         q_count_ff   <= q_count_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      q0_ff      <= q0_in;
      q1_ff      <= q1_in;
   end

   assign rsp_tvalid = (q_count_ff != 2'd0);
   assign rsp_tdata  = {1'b0, q0_ff.char_code};
   assign rsp_tlast  = q0_ff.password_last;
   assign rsp_tuser  = q0_ff.run_last;

   // The result buffer holds at most two characters.
   a_buffer_depth: assert property (@(posedge clock) disable iff (reset)
      q_count_ff != 2'd3)
      else $error("result buffer count out of range");

   // Between bytes at most six bits remain in the reservoir.
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= 4'd6)
      else $error("reservoir holds more bits than a byte can follow");

   // A completed password restarts the character count.
   a_password_restart: assert property (@(posedge clock) disable iff (reset)
      process && draw.ended |=> chars_ff == '0 && held_ff == '0)
      else $error("state not cleared after password end");

   // A held byte waiting for buffer space is neither lost nor altered.
   a_byte_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !process |=> in_valid_ff && $stable(in_byte_ff))
      else $error("pending byte lost or changed");

endmodule

FILE: rtl/core/crs_draw.sv
module crs_draw #(
   parameter int MAX_PASSWORD = 128
) (
   input  logic [7:0]                          rand_byte,
   input  crs_pkg::crs_mode_type               mode,
   input  logic [7:0]                          password_length,
   input  logic [crs_pkg::RESERVOIR_W-1:0]     reservoir,
   input  logic [crs_pkg::HELD_W-1:0]          held,
   input  logic [crs_pkg::COUNT_W-1:0]         chars,
   output crs_pkg::crs_draw_type               draw
);
   import crs_pkg::*;

   logic [WIDTH_W-1:0]     k;
   logic [SAMPLE_W-1:0]    kmask;
   logic [SAMPLE_W-1:0]    universe;
   logic [COUNT_W-1:0]     len;
   logic [RESERVOIR_W-1:0] res_w;
   logic [HELD_W-1:0]      held_w;
   logic [COUNT_W-1:0]     chars_w;
   logic [1:0]             n;
   logic                   stop;
   logic [SAMPLE_W-1:0]    sample;
   logic                   done;
   crs_result_type         cur;
   crs_result_type         r0;
   crs_result_type         r1;

   assign k        = mode_width(mode);
   assign kmask    = 7'((8'd1 << k) - 8'd1);
   assign universe = mode_universe(mode);

   always_comb begin
      if (password_length < 8'(MIN_PASSWORD))      len = 8'(MIN_PASSWORD);
      else if (password_length > 8'(MAX_PASSWORD)) len = 8'(MAX_PASSWORD);
      else                                         len = password_length;
   end

   // Held bits never exceed six between bytes, so a whole byte always fits.
   // At most three draws happen per byte (four-bit samples from fourteen bits).
   always_comb begin
      res_w   = reservoir | (14'(rand_byte) << held);
      held_w  = held + 4'd8;
      chars_w = chars;
      n       = 2'd0;
      stop    = 1'b0;
      sample  = '0;
      done    = 1'b0;
      cur     = '0;
      r0      = '0;
      r1      = '0;
      for (int i = 0; i < 3; i++) begin
         if (!stop && held_w >= {1'b0, k} && n != 2'd2) begin
            sample = res_w[SAMPLE_W-1:0] & kmask;
            res_w  = res_w >> k;
            held_w = held_w - {1'b0, k};
            if (sample < universe) begin
               chars_w = chars_w + 8'd1;
               done    = (chars_w >= len) || (chars_w == 8'd0);
               cur.char_code     = map_symbol(mode, sample);
               cur.password_last = done;
               cur.run_last      = 1'b0;
               if (n == 2'd0) r0 = cur;
               else           r1 = cur;
               n = n + 2'd1;
               if (done) begin
                  res_w   = '0;
                  held_w  = '0;
                  chars_w = '0;
                  stop    = 1'b1;
               end
            end
         end
      end
      if (n == 2'd1)      r0.run_last = 1'b1;
      else if (n == 2'd2) r1.run_last = 1'b1;
   end

   assign draw.res0      = r0;
   assign draw.res1      = r1;
   assign draw.num       = n;
   assign draw.reservoir = res_w;
   assign draw.held      = held_w;
   assign draw.chars     = chars_w;
   assign draw.ended     = stop;

endmodule
